### design/lbip_pkg.sv
// ----------------------------------------------------------------------------
// lbip_pkg
// Shared types, constants and block size decode for the logical block to
// indirect path mapper.
// ----------------------------------------------------------------------------
package lbip_pkg;

	localparam int LB_W         = 48;
	localparam int BS_W         = 18;
	localparam int IDX_W        = 14;
	localparam int SHIFT_W      = 4;
	localparam int SHIFT2_W     = 5;
	localparam int SLOT_W       = 4;
	localparam int DEPTH_W      = 3;
	localparam int DIRECT_SLOTS = 12;

	localparam logic [BS_W-1:0] BS_RESET = BS_W'(1024);

	localparam logic [SLOT_W-1:0] SLOT_IND  = SLOT_W'(DIRECT_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_DBL  = SLOT_W'(DIRECT_SLOTS + 1);
	localparam logic [SLOT_W-1:0] SLOT_TRPL = SLOT_W'(DIRECT_SLOTS + 2);

	localparam logic [DEPTH_W-1:0] DEPTH_NONE   = 3'd0;
	localparam logic [DEPTH_W-1:0] DEPTH_DIRECT = 3'd1;
	localparam logic [DEPTH_W-1:0] DEPTH_IND    = 3'd2;
	localparam logic [DEPTH_W-1:0] DEPTH_DBL    = 3'd3;
	localparam logic [DEPTH_W-1:0] DEPTH_TRPL   = 3'd4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	// Decoded block size: shift amounts, pointer mask and region bounds
	typedef struct packed {
		logic                valid;
		logic [SHIFT_W-1:0]  shift;
		logic [SHIFT2_W-1:0] shift2;
		logic [IDX_W-1:0]    pmask;
		logic [LB_W-1:0]     base2;
		logic [LB_W-1:0]     base3;
		logic [LB_W-1:0]     limit;
	} cfg_t;

	typedef struct packed {
		status_t             status;
		logic [DEPTH_W-1:0]  depth;
		logic [SLOT_W-1:0]   slot;
		logic [IDX_W-1:0]    l1;
		logic [IDX_W-1:0]    l2;
		logic [IDX_W-1:0]    l3;
		logic [IDX_W-1:0]    bd;
	} result_t;

	function automatic cfg_t decode_block_size(input logic [BS_W-1:0] bs);
		cfg_t            c;
		logic [LB_W-1:0] ptrs;
		logic [LB_W-1:0] dcap;
		logic [LB_W-1:0] tcap;
		c = '0;
		for (int k = 10; k <= 16; k++) begin
			if (bs == (BS_W'(1) << k)) begin
				c.valid = 1'b1;
				c.shift = SHIFT_W'(k - 2);
			end
		end
		c.shift2 = {c.shift, 1'b0};
		ptrs     = LB_W'(1) << c.shift;
		dcap     = ptrs << c.shift;
		tcap     = dcap << c.shift;
		c.pmask  = IDX_W'(ptrs - LB_W'(1));
		c.base2  = LB_W'(DIRECT_SLOTS) + ptrs;
		c.base3  = c.base2 + dcap;
		c.limit  = c.base3 + tcap;
		return c;
	endfunction

endpackage

### design/lbip_cfg.sv
// ----------------------------------------------------------------------------
// lbip_cfg
// Block size register, kept in decoded form (shifts, mask, region bounds).
// ----------------------------------------------------------------------------
module lbip_cfg import lbip_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  logic [BS_W-1:0] wdata,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= decode_block_size(BS_RESET);
		end else if (we) begin
			cfg_q <= decode_block_size(wdata);
		end
	end

	assign cfg = cfg_q;

endmodule

### design/lbip_map.sv
// ----------------------------------------------------------------------------
// lbip_map
// Combinational path mapping: region select, subtracts, shifts and masks.
// ----------------------------------------------------------------------------
module lbip_map import lbip_pkg::*; (
	input  logic [LB_W-1:0] lb,
	input  cfg_t            cfg,
	output result_t         res
);

	logic             in_direct;
	logic             in_ind;
	logic             in_dbl;
	logic             in_reach;
	logic [LB_W-1:0]  base;
	logic [LB_W-1:0]  rel;
	logic [LB_W-1:0]  rel_sh1;
	logic [LB_W-1:0]  rel_sh2;
	logic [IDX_W-1:0] low_idx;
	logic [IDX_W-1:0] mid_idx;

	assign in_direct = lb < LB_W'(DIRECT_SLOTS);
	assign in_ind    = lb < cfg.base2;
	assign in_dbl    = lb < cfg.base3;
	assign in_reach  = lb < cfg.limit;

	assign base    = in_ind ? LB_W'(DIRECT_SLOTS) : (in_dbl ? cfg.base2 : cfg.base3);
	assign rel     = lb - base;
	assign rel_sh1 = rel >> cfg.shift;
	assign rel_sh2 = rel >> cfg.shift2;
	assign low_idx = rel[IDX_W-1:0] & cfg.pmask;
	assign mid_idx = rel_sh1[IDX_W-1:0] & cfg.pmask;

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		if (!cfg.valid) begin
			res.status = ST_BAD_SIZE;
		end else if (in_direct) begin
			res.depth = DEPTH_DIRECT;
			res.slot  = lb[SLOT_W-1:0];
			res.bd    = IDX_W'(DIRECT_SLOTS - 1) - lb[IDX_W-1:0];
		end else if (in_ind) begin
			res.depth = DEPTH_IND;
			res.slot  = SLOT_IND;
			res.l1    = rel[IDX_W-1:0];
			res.bd    = cfg.pmask - rel[IDX_W-1:0];
		end else if (in_dbl) begin
			res.depth = DEPTH_DBL;
			res.slot  = SLOT_DBL;
			res.l1    = rel_sh1[IDX_W-1:0];
			res.l2    = low_idx;
			res.bd    = cfg.pmask - low_idx;
		end else if (!in_reach) begin
			res.status = ST_RANGE;
		end else begin
			res.depth = DEPTH_TRPL;
			res.slot  = SLOT_TRPL;
			res.l1    = rel_sh2[IDX_W-1:0];
			res.l2    = mid_idx;
			res.l3    = low_idx;
			res.bd    = cfg.pmask - low_idx;
		end
	end

endmodule

### design/logical_block_to_indirect_path_top.sv
// ----------------------------------------------------------------------------
// logical_block_to_indirect_path_top
// Maps a logical block number to its inode slot and indirect block indexes.
// ----------------------------------------------------------------------------
// Registers: input reg, then result reg; done is high for one cycle per result.
// Throughput: one item per cycle; the mapping path between the two registers
// is a set of 48-bit compares, subtracts and barrel shifts.
// busy is held low and results cannot be held off, so nothing ever stalls.
// Reset clears the pipeline valids and sets the block size to 1024.
module logical_block_to_indirect_path_top import lbip_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [BS_W-1:0]     cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic [LB_W-1:0]     blk_num,
	output logic                done,
	output logic [1:0]          status,
	output logic [DEPTH_W-1:0]  depth,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [IDX_W-1:0]    level_one_index,
	output logic [IDX_W-1:0]    level_two_index,
	output logic [IDX_W-1:0]    level_three_index,
	output logic [IDX_W-1:0]    boundary
);

	cfg_t            cfg;
	result_t         res;
	logic            valid_s1;
	logic [LB_W-1:0] lb_s1;
	logic            done_s2;
	result_t         res_s2;

	lbip_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	lbip_map u_map (
		.lb  (lb_s1),
		.cfg (cfg),
		.res (res)
	);

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			lb_s1 <= blk_num;
		end
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	assign done              = done_s2;
	assign status            = res_s2.status;
	assign depth             = res_s2.depth;
	assign slot_index        = res_s2.slot;
	assign level_one_index   = res_s2.l1;
	assign level_two_index   = res_s2.l2;
	assign level_three_index = res_s2.l3;
	assign boundary          = res_s2.bd;

endmodule

### design/lbip_checker.sv
// ----------------------------------------------------------------------------
// lbip_checker
// Port-level checks on item timing and result consistency.
// ----------------------------------------------------------------------------
module lbip_checker import lbip_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [1:0]          status,
	input logic [DEPTH_W-1:0]  depth,
	input logic [SLOT_W-1:0]   slot_index,
	input logic [IDX_W-1:0]    level_one_index,
	input logic [IDX_W-1:0]    level_two_index,
	input logic [IDX_W-1:0]    level_three_index,
	input logic [IDX_W-1:0]    boundary
);

	// every accepted item gives exactly one result
	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted item produced no result");

	a_done_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted item");

	// errors clear the whole path
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> depth == DEPTH_NONE && slot_index == '0 &&
			level_one_index == '0 && level_two_index == '0 &&
			level_three_index == '0 && boundary == '0)
		else $error("error result with nonzero path");

	// ok results have a depth, and levels past the depth are zero
	a_ok_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_OK |-> depth != DEPTH_NONE &&
			(depth == DEPTH_TRPL || level_three_index == '0) &&
			(depth == DEPTH_TRPL || depth == DEPTH_DBL || level_two_index == '0) &&
			(depth != DEPTH_DIRECT || level_one_index == '0))
		else $error("path levels inconsistent with depth");

endmodule

bind logical_block_to_indirect_path_top lbip_checker u_lbip_checker (.*);
